// ===== src/glef_pkg.sv =====
// Shared types and constants for the gray Laplacian edge filter.
// No dependencies; imported by every module of the block.
`default_nettype none
package glef_pkg;

	localparam int MAX_WIDTH    = 1024;
	localparam int HEIGHT_LIMIT = 4096;
	localparam int COL_W        = $clog2(MAX_WIDTH);
	localparam int ROW_W        = 12;
	localparam int WCFG_W       = 11;
	localparam int HCFG_W       = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_IDX_W    = 1;
	localparam int PIX_W        = 8;

	localparam logic [WCFG_W-1:0] WIDTH_RESET  = WCFG_W'(640);
	localparam logic [HCFG_W-1:0] HEIGHT_RESET = HCFG_W'(480);
	localparam logic [WCFG_W-1:0] WIDTH_MIN    = WCFG_W'(3);
	localparam logic [WCFG_W-1:0] WIDTH_MAX    = WCFG_W'(MAX_WIDTH);
	localparam logic [HCFG_W-1:0] HEIGHT_MIN   = HCFG_W'(3);
	localparam logic [HCFG_W-1:0] HEIGHT_MAX   = HCFG_W'(HEIGHT_LIMIT);

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

	// floor(s/3) for s <= 765 as (s * 683) >> 11
	localparam int GRAY_RECIP = 683;
	localparam int GRAY_SHIFT = 11;

	typedef logic [PIX_W-1:0] pix_t;

	// position of one pixel and what it causes
	typedef struct packed {
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             produce;
		logic             last;
	} pos_t;

endpackage
`default_nettype wire

// ===== src/gray_laplacian_edge_filter_core.sv =====
// Gray Laplacian edge filter, top level: gray conversion, pipeline control, output register.
// Depends on glef_pkg, glef_position, glef_line_store, glef_window.
//
// Usage:
//   Input channel (in_valid/in_ready, red/green/blue) takes one RGB pixel per
//   transaction in raster order. Each pixel becomes gray = floor((r+g+b)/3).
//   Output channel (out_valid/out_ready) gives one transaction per interior
//   pixel: the clamped value up+down+left+right-4*centre, its column/row, and
//   frame_last on the final interior result of the frame. Border pixels
//   produce no transaction; a result appears once the pixel below-right of
//   the centre has been taken.
//   Throughput: one pixel per cycle sustained while out_ready stays high.
//   out_valid is registered: the line-memory read register loads on the edge
//   that takes the causing pixel, the output register when stage 1 fires.
//   Config: cfg_we writes cfg_data to register cfg_index (0 width, 1 height);
//   write only between frames or while idle.
//   Reset: arst_n clears counters and valids and loads 640 x 480. Line
//   memories are not cleared; no result ever depends on an unwritten entry.
//   Stall: if out_ready is low with a result pending, the compute stage holds
//   one more pixel, then in_ready drops until the output drains.
`default_nettype none
module gray_laplacian_edge_filter_core (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [glef_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [glef_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire [7:0]                       red,
	input  wire [7:0]                       green,
	input  wire [7:0]                       blue,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [7:0]                      edge_value,
	output logic [glef_pkg::COL_W-1:0]      out_col,
	output logic [glef_pkg::ROW_W-1:0]      out_row,
	output logic                            frame_last
);
	import glef_pkg::*;

	localparam int SUM_W  = PIX_W + 2;
	localparam int PROD_W = 2 * SUM_W;

	logic accept, s1_fire;
	pos_t pos_cur;

	// stage 1: pixel whose line-memory reads are being returned
	logic valid_s1;
	pix_t gray_s1;
	pos_t pos_s1;

	pix_t up_rd, mid_rd, edge_cur;

	logic [SUM_W-1:0]  rgb_sum;
	logic [PROD_W-1:0] gray_prod;
	pix_t              gray_cur;

	// stage 2: output register
	logic out_valid_s2;
	pix_t edge_s2;
	logic [COL_W-1:0] col_s2;
	logic [ROW_W-1:0] row_s2;
	logic last_s2;

	assign s1_fire  = valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !valid_s1 || s1_fire;
	assign accept   = in_valid && in_ready;

	// divide by 3 through a reciprocal multiply
	assign rgb_sum   = {2'b0, red} + {2'b0, green} + {2'b0, blue};
	assign gray_prod = {{SUM_W{1'b0}}, rgb_sum} * PROD_W'(GRAY_RECIP);
	assign gray_cur  = gray_prod[GRAY_SHIFT+PIX_W-1:GRAY_SHIFT];

	glef_position u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.advance   (accept),
		.pos       (pos_cur)
	);

	// read at the column of the pixel being taken; write back when it retires.
	// Successive columns always differ, so the pending write never collides.
	glef_line_store u_lines (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr   (pos_cur.col),
		.wr_en     (s1_fire),
		.wr_addr   (pos_s1.col),
		.wr_upper  (mid_rd),
		.wr_middle (gray_s1),
		.up_rd     (up_rd),
		.mid_rd    (mid_rd)
	);

	glef_window u_win (
		.clk      (clk),
		.shift_en (s1_fire),
		.up_in    (up_rd),
		.mid_in   (mid_rd),
		.gray_in  (gray_s1),
		.edge_out (edge_cur)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (accept)
			valid_s1 <= 1'b1;
		else if (s1_fire)
			valid_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			gray_s1 <= gray_cur;
			pos_s1  <= pos_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_s2 <= 1'b0;
		else if (s1_fire)
			out_valid_s2 <= pos_s1.produce;
		else if (out_ready)
			out_valid_s2 <= 1'b0;
	end

	// result coordinates refer to the centre, one up and one left
	always_ff @(posedge clk) begin
		if (s1_fire && pos_s1.produce) begin
			edge_s2 <= edge_cur;
			col_s2  <= pos_s1.col - COL_W'(1);
			row_s2  <= pos_s1.row - ROW_W'(1);
			last_s2 <= pos_s1.last;
		end
	end

	assign out_valid  = out_valid_s2;
	assign edge_value = edge_s2;
	assign out_col    = col_s2;
	assign out_row    = row_s2;
	assign frame_last = last_s2;

	// empty compute stage never blocks input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("in_ready low with empty compute stage");

	// a taken pixel always lands in the compute stage
	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted pixel lost before compute stage");

	// never overwrite a pending, untaken result
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_s2 && !out_ready) |-> !s1_fire)
		else $error("pending result overwritten");

	// results are interior pixels only
	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_s2 |-> (col_s2 != '0 && row_s2 != '0))
		else $error("border pixel produced a result");

endmodule
`default_nettype wire

// ===== src/glef_position.sv =====
// Size registers and raster column/row counters.
// Depends on glef_pkg.
`default_nettype none
module glef_position (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             cfg_we,
	input  wire [glef_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire [glef_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire                             advance,
	output glef_pkg::pos_t                  pos
);
	import glef_pkg::*;

	logic [WCFG_W-1:0] width_cfg_q;
	logic [HCFG_W-1:0] height_cfg_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;

	logic [WCFG_W-1:0] w_eff;
	logic [HCFG_W-1:0] h_eff;
	logic [HCFG_W-1:0] row_pre;
	logic [COL_W-1:0]  c_cur;
	logic [ROW_W-1:0]  r_cur;
	logic [WCFG_W-1:0] c_next;
	logic [HCFG_W-1:0] r_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= WIDTH_RESET;
			height_cfg_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_cfg_q  <= cfg_data[WCFG_W-1:0];
				REG_IMAGE_HEIGHT: height_cfg_q <= cfg_data[HCFG_W-1:0];
			endcase
		end
	end

	always_comb begin
		w_eff = width_cfg_q;
		if (width_cfg_q < WIDTH_MIN) w_eff = WIDTH_MIN;
		if (width_cfg_q > WIDTH_MAX) w_eff = WIDTH_MAX;
		h_eff = height_cfg_q;
		if (height_cfg_q < HEIGHT_MIN) h_eff = HEIGHT_MIN;
		if (height_cfg_q > HEIGHT_MAX) h_eff = HEIGHT_MAX;

		// counters left past the size by a mid-frame size change
		if ({1'b0, col_q} >= w_eff) begin
			c_cur   = '0;
			row_pre = {1'b0, row_q} + HCFG_W'(1);
		end else begin
			c_cur   = col_q;
			row_pre = {1'b0, row_q};
		end
		r_cur = (row_pre >= h_eff) ? '0 : row_pre[ROW_W-1:0];

		c_next = {1'b0, c_cur} + WCFG_W'(1);
		r_next = {1'b0, r_cur} + HCFG_W'(1);

		pos.col     = c_cur;
		pos.row     = r_cur;
		pos.produce = (r_cur >= ROW_W'(2)) && (c_cur >= COL_W'(2));
		pos.last    = ({1'b0, r_cur} == h_eff - HCFG_W'(1)) &&
		              ({1'b0, c_cur} == w_eff - WCFG_W'(1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (c_next >= w_eff) begin
				col_q <= '0;
				row_q <= (r_next >= h_eff) ? '0 : r_next[ROW_W-1:0];
			end else begin
				col_q <= c_next[COL_W-1:0];
				row_q <= r_cur;
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/glef_line_store.sv =====
// Two line memories holding the gray values of the previous two rows.
// Depends on glef_pkg.
`default_nettype none
module glef_line_store (
	input  wire                        clk,
	input  wire                        rd_en,
	input  wire [glef_pkg::COL_W-1:0]  rd_addr,
	input  wire                        wr_en,
	input  wire [glef_pkg::COL_W-1:0]  wr_addr,
	input  glef_pkg::pix_t             wr_upper,
	input  glef_pkg::pix_t             wr_middle,
	output glef_pkg::pix_t             up_rd,
	output glef_pkg::pix_t             mid_rd
);
	import glef_pkg::*;

	pix_t upper_mem  [MAX_WIDTH];
	pix_t middle_mem [MAX_WIDTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			upper_mem[wr_addr]  <= wr_upper;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	// read data holds while the consuming stage is stalled
	always_ff @(posedge clk) begin
		if (rd_en) begin
			up_rd  <= upper_mem[rd_addr];
			mid_rd <= middle_mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== src/glef_window.sv =====
// 3x3 neighborhood window and four-neighbor Laplacian with clamp.
// Depends on glef_pkg.
`default_nettype none
module glef_window (
	input  wire             clk,
	input  wire             shift_en,
	input  glef_pkg::pix_t  up_in,
	input  glef_pkg::pix_t  mid_in,
	input  glef_pkg::pix_t  gray_in,
	output glef_pkg::pix_t  edge_out
);
	import glef_pkg::*;

	pix_t top1_q, mid1_q, mid2_q, bot1_q;
	logic signed [PIX_W+3:0] lap;

	always_comb begin
		lap = $signed({4'b0, top1_q}) + $signed({4'b0, bot1_q})
		    + $signed({4'b0, mid2_q}) + $signed({4'b0, mid_in})
		    - $signed({2'b0, mid1_q, 2'b0});
		if (lap < 0)
			edge_out = '0;
		else if (lap > $signed((PIX_W+4)'(255)))
			edge_out = '1;
		else
			edge_out = lap[PIX_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			top1_q <= up_in;
			mid2_q <= mid1_q;
			mid1_q <= mid_in;
			bot1_q <= gray_in;
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking bench for gray_laplacian_edge_filter_core: RGB pixel stream in, edge results out.
// Needs glef_pkg and the core; a built-in predictor tracks line stores, window and position.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import glef_pkg::*;

	localparam int CHANNELS   = 3;
	localparam int SETTLE_CYC = 4;   // read stage + output register, with margin

	typedef struct packed {
		pix_t red;
		pix_t green;
		pix_t blue;
	} rgb_t;

	typedef struct packed {
		logic [7:0]       value;
		logic [COL_W-1:0] col;
		logic [ROW_W-1:0] row;
		logic             last;
	} edge_result_t;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	pix_t                  red = '0;
	pix_t                  green = '0;
	pix_t                  blue = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [7:0]            edge_value;
	logic [COL_W-1:0]      out_col;
	logic [ROW_W-1:0]      out_row;
	logic                  frame_last;

	gray_laplacian_edge_filter_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.red       (red),
		.green     (green),
		.blue      (blue),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.edge_value(edge_value),
		.out_col   (out_col),
		.out_row   (out_row),
		.frame_last(frame_last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Predictor state: raw size registers, two line stores, the part of
	// the 3x3 window the four-neighbour kernel needs, next pixel position.
	// ------------------------------------------------------------------
	int unsigned size_width  = WIDTH_RESET;
	int unsigned size_height = HEIGHT_RESET;
	pix_t        upper_line  [MAX_WIDTH];
	pix_t        middle_line [MAX_WIDTH];
	pix_t        win_top1 = '0;    // row above, one column back (up)
	pix_t        win_mid1 = '0;    // centre
	pix_t        win_mid2 = '0;    // left of centre
	pix_t        win_bot1 = '0;    // row below, one column back (down)
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;

	edge_result_t expected_edges[$];
	rgb_t         pixel_q[$];

	int unsigned pixels_queued = 0;
	int unsigned pixels_taken  = 0;
	int          errors        = 0;

	// idle shaping, switched per phase by the stimulus process
	bit feed_steady  = 1'b0;
	bit drain_steady = 1'b0;

	// out-of-range sizes clamp to the supported span
	function automatic int unsigned active_width();
		if (size_width < WIDTH_MIN) return WIDTH_MIN;
		if (size_width > WIDTH_MAX) return WIDTH_MAX;
		return size_width;
	endfunction

	function automatic int unsigned active_height();
		if (size_height < HEIGHT_MIN) return HEIGHT_MIN;
		if (size_height > HEIGHT_MAX) return HEIGHT_MAX;
		return size_height;
	endfunction

	// One accepted pixel: gray conversion, kernel on the window, store update.
	function automatic void predict_edge(input pix_t r, input pix_t g, input pix_t b);
		int unsigned  w;
		int unsigned  h;
		int unsigned  gray;
		pix_t         above;
		pix_t         right_px;
		int           sum;
		edge_result_t res;
		w = active_width();
		h = active_height();
		// a size change mid-frame is resolved here, on the next pixel
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		gray = (int'(r) + int'(g) + int'(b)) / CHANNELS;
		above = upper_line[col_pos];
		right_px = middle_line[col_pos];
		// centre sits one column back and one row up from the new pixel
		if (row_pos >= 2 && col_pos >= 2) begin
			sum = int'(win_top1) + int'(win_bot1) + int'(win_mid2) + int'(right_px)
				- 4 * int'(win_mid1);
			if (sum < 0)
				sum = 0;
			else if (sum > 255)
				sum = 255;
			res.value = sum[7:0];
			res.col = COL_W'(col_pos - 1);
			res.row = ROW_W'(row_pos - 1);
			res.last = (row_pos == h - 1) && (col_pos == w - 1);
			expected_edges.push_back(res);
		end
		win_top1 = above;
		win_mid2 = win_mid1;
		win_mid1 = right_px;
		win_bot1 = pix_t'(gray);
		upper_line[col_pos] = right_px;
		middle_line[col_pos] = pix_t'(gray);
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	// ------------------------------------------------------------------
	// Input driver: one transaction per queued pixel, random gap before
	// each new one unless feed_steady is set. Prediction runs on the edge that takes the pixel.
	// ------------------------------------------------------------------
	int   gap_left = 0;
	rgb_t next_pixel;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left <= 0;
		end else begin
			if (in_valid && in_ready) begin
				predict_edge(red, green, blue);
				pixels_taken++;
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					in_valid <= 1'b0;
					gap_left <= gap_left - 1;
				end else if (pixel_q.size() != 0) begin
					next_pixel = pixel_q.pop_front();
					in_valid <= 1'b1;
					red <= next_pixel.red;
					green <= next_pixel.green;
					blue <= next_pixel.blue;
					gap_left <= feed_steady ? 0 : $urandom_range(0, 5);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Output monitor: compares each result transaction with the oldest
	// expectation, then holds ready low for a random stall unless drain_steady is set.
	// ------------------------------------------------------------------
	int           stall_left = 0;
	int           stall_next;
	edge_result_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			stall_next = stall_left;
			if (out_valid && out_ready) begin
				if (expected_edges.size() == 0) begin
					$display("%0t ns: unexpected result, expected none, actual value %0d col %0d row %0d last %0b",
						$time, edge_value, out_col, out_row, frame_last);
					errors++;
				end else begin
					want = expected_edges.pop_front();
					if (edge_value !== want.value) begin
						$display("%0t ns: edge_value expected %0d actual %0d (col %0d row %0d)",
							$time, want.value, edge_value, want.col, want.row);
						errors++;
					end
					if (out_col !== want.col) begin
						$display("%0t ns: out_col expected %0d actual %0d",
							$time, want.col, out_col);
						errors++;
					end
					if (out_row !== want.row) begin
						$display("%0t ns: out_row expected %0d actual %0d",
							$time, want.row, out_row);
						errors++;
					end
					if (frame_last !== want.last) begin
						$display("%0t ns: frame_last expected %0b actual %0b (col %0d row %0d)",
							$time, want.last, frame_last, want.col, want.row);
						errors++;
					end
				end
				stall_next = drain_steady ? 0 : $urandom_range(0, 5);
			end
			if (stall_next > 0) begin
				out_ready <= 1'b0;
				stall_left <= stall_next - 1;
			end else begin
				out_ready <= 1'b1;
				stall_left <= 0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Stimulus helpers
	// ------------------------------------------------------------------
	task automatic queue_pixel(input pix_t r, input pix_t g, input pix_t b);
		rgb_t px;
		px.red = r;
		px.green = g;
		px.blue = b;
		pixel_q.push_back(px);
		pixels_queued++;
	endtask

	// flat black/white areas drive the clamp, flat gray keeps values small
	task automatic queue_random_pixel();
		pix_t v;
		v = pix_t'($urandom);
		case ($urandom_range(0, 9))
			0, 1: queue_pixel(8'h00, 8'h00, 8'h00);
			2, 3: queue_pixel(8'hFF, 8'hFF, 8'hFF);
			4, 5: queue_pixel(v, v, v);
			default: queue_pixel(pix_t'($urandom), pix_t'($urandom), pix_t'($urandom));
		endcase
	endtask

	// Register write; the predictor takes the new value on the same edge.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(value);
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_IMAGE_WIDTH)
			size_width = value & 32'h7FF;
		else
			size_height = value & 32'h1FFF;
	endtask

	// Block idle: every pixel taken, every result seen, pipeline flushed.
	task automatic settle();
		while (pixels_taken != pixels_queued || expected_edges.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	// Pixels left in the current frame under the size now in force.
	function automatic int unsigned pixels_to_frame_end();
		int unsigned c;
		int unsigned r;
		int unsigned w;
		int unsigned h;
		c = col_pos;
		r = row_pos;
		w = active_width();
		h = active_height();
		if (c >= w) begin
			c = 0;
			r++;
		end
		if (r >= h)
			r = 0;
		return (h - r) * w - c;
	endfunction

	// ------------------------------------------------------------------
	// Sequence: reset, directed corners, warm-up frame, random phases.
	// Sizes change only with the block idle.
	// ------------------------------------------------------------------
	initial begin
		int unsigned random_sent;
		int unsigned n;
		int unsigned w_val;
		int unsigned h_val;
		int          kind;
		bit          wide;

		random_sent = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size 640 x 480: part of row 0 only, nothing comes out
		queue_pixel(8'd255, 8'd255, 8'd254);   // gray 254
		queue_pixel(8'd255, 8'd255, 8'd255);   // full-scale sum
		queue_pixel(8'd1, 8'd1, 8'd0);         // truncates to 0
		queue_pixel(8'd0, 8'd0, 8'd0);
		settle();

		// width and height below minimum, set mid-row: column 4 is past
		// the new width, so the next pixel opens row 1
		write_reg(REG_IMAGE_WIDTH, 0);
		write_reg(REG_IMAGE_HEIGHT, 1);
		// black centre, white neighbours: positive clamp, last of frame
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd0, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);
		queue_pixel(8'd0, 8'd0, 8'd255);
		settle();

		// minimum width, height 2 acts as 3: unclamped small response
		write_reg(REG_IMAGE_WIDTH, 3);
		write_reg(REG_IMAGE_HEIGHT, 2);
		queue_pixel(8'd255, 8'd0, 8'd0);
		queue_pixel(8'd255, 8'd255, 8'd255);   // up
		queue_pixel(8'd0, 8'd255, 8'd0);
		queue_pixel(8'd0, 8'd0, 8'd0);         // left
		queue_pixel(8'd100, 8'd100, 8'd100);   // centre
		queue_pixel(8'd50, 8'd50, 8'd50);      // right
		queue_pixel(8'd0, 8'd0, 8'd255);
		queue_pixel(8'd100, 8'd101, 8'd99);    // down
		queue_pixel(8'd128, 8'd64, 8'd32);
		settle();

		// largest register values, then the exact limits, mid-row
		write_reg(REG_IMAGE_WIDTH, 2047);
		write_reg(REG_IMAGE_HEIGHT, 8191);
		repeat (5) queue_random_pixel();
		settle();
		write_reg(REG_IMAGE_WIDTH, MAX_WIDTH);
		write_reg(REG_IMAGE_HEIGHT, HEIGHT_LIMIT);
		repeat (2) queue_random_pixel();
		settle();

		// 64-wide frame: fills line-store entries 0..63, so any later
		// narrow phase or mid-frame change reads only written entries
		write_reg(REG_IMAGE_WIDTH, 64);
		write_reg(REG_IMAGE_HEIGHT, 3);
		n = pixels_to_frame_end();
		repeat (n) queue_random_pixel();

		// random phases: mostly whole frames of small size, some cut
		// short so the next size lands mid-frame
		while (random_sent < 940) begin
			settle();
			feed_steady = ($urandom_range(0, 3) == 0);
			drain_steady = ($urandom_range(0, 3) == 0);
			kind = $urandom_range(0, 19);
			wide = ($urandom_range(0, 19) == 0) && (col_pos < 60);
			if (wide)
				w_val = $urandom_range(MAX_WIDTH, 2047);
			else if ($urandom_range(0, 7) == 0)
				w_val = $urandom_range(0, 2);
			else if ($urandom_range(0, 4) == 0)
				w_val = $urandom_range(13, 64);
			else
				w_val = $urandom_range(3, 12);
			write_reg(REG_IMAGE_WIDTH, w_val);
			if ($urandom_range(0, 3) != 0) begin
				case ($urandom_range(0, 9))
					0: h_val = $urandom_range(0, 2);
					1: h_val = $urandom_range(HEIGHT_LIMIT, 8191);
					default: h_val = $urandom_range(3, 9);
				endcase
				write_reg(REG_IMAGE_HEIGHT, h_val);
			end
			n = pixels_to_frame_end();
			// wide rows stay below column 64, inside the written entries
			if (wide)
				n = $urandom_range(1, 64 - col_pos);
			else if (kind >= 14 || n > 700)
				n = $urandom_range(1, 60);
			repeat (n) queue_random_pixel();
			random_sent += n;
		end

		settle();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule
